// ===== src/fmpf_pkg.sv =====
// Package: shared types and constants of the prefix rule filter.
`default_nettype none

package fmpf_pkg;

    localparam int REQ_W    = 2;
    localparam int RIDX_W   = 3;
    localparam int CPOS_W   = 5;
    localparam int BYTE_W   = 8;
    localparam int RLEN_W   = 6;
    localparam int MATCH_W  = 4;
    localparam int ACTIVE_W = 4;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_LOAD_CHAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_LEN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RECORD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RULES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_OFFSET  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [RIDX_W-1:0] rule_index;
        logic [CPOS_W-1:0] char_pos;
        logic [BYTE_W-1:0] rule_char;
        logic [RLEN_W-1:0] rule_length;
        logic              rule_allow;
        logic [BYTE_W-1:0] data_byte;
        logic              is_last;
    } t_req;

    typedef struct packed {
        logic               decided;
        logic               short_record;
        logic               allowed;
        logic [MATCH_W-1:0] matched_rule;
    } t_verdict;

endpackage

`default_nettype wire

// ===== src/fmpf_if.sv =====
// Interfaces: input word, result word and configuration write channels.
`default_nettype none

interface fmpf_in_if import fmpf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [RIDX_W-1:0] rule_index;
    logic [CPOS_W-1:0] char_pos;
    logic [BYTE_W-1:0] rule_char;
    logic [RLEN_W-1:0] rule_length;
    logic              rule_allow;
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;

    modport source (
        output valid, req_type, rule_index, char_pos, rule_char,
               rule_length, rule_allow, data_byte, is_last,
        input  ready
    );
    modport sink (
        input  valid, req_type, rule_index, char_pos, rule_char,
               rule_length, rule_allow, data_byte, is_last,
        output ready
    );
endinterface

interface fmpf_out_if import fmpf_pkg::*;;
    logic               valid;
    logic               ready;
    logic               allowed;
    logic               short_record;
    logic [MATCH_W-1:0] matched_rule;

    modport source (output valid, allowed, short_record, matched_rule, input ready);
    modport sink (input valid, allowed, short_record, matched_rule, output ready);
endinterface

interface fmpf_cfg_if import fmpf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/fmpf_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none

module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/fmpf_head.sv =====
// Head stage: byte counter, text position, field length and short check.
`default_nettype none

module fmpf_head import fmpf_pkg::*; #(
    parameter int NUM_RULES  = 8,
    parameter int MAX_PREFIX = 32,
    parameter int AW         = 5,
    parameter int LW         = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CNT_W-1:0]  i_event_size,
    input  wire logic [CNT_W-1:0]  i_text_offset,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire t_req              i_req,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      t_req              o_req,
    output      logic [AW-1:0]     o_qa,
    output      logic              o_qhit,
    output      logic [LW-1:0]     o_field,
    output      t_verdict          o_verdict
);
    logic             r_valid;
    logic [CNT_W-1:0] r_count;
    t_req             r_req;
    logic [AW-1:0]    r_qa;
    logic             r_qhit;
    logic [LW-1:0]    r_field;
    t_verdict         r_verdict;

    logic             accept;
    logic             is_record;
    logic [CNT_W:0]   qdiff;
    logic             qhit;
    logic [CNT_W-1:0] len;
    logic [CNT_W:0]   fdiff;
    logic [CNT_W-1:0] field;
    logic [LW-1:0]    field_cap;
    logic             short_rec;
    t_verdict         verdict;

    assign o_ready   = !r_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign is_record = (i_req.req_type == REQ_RECORD);

    always_comb begin
        qdiff     = {1'b0, r_count} - {1'b0, i_text_offset};
        qhit      = !qdiff[CNT_W] && (qdiff[CNT_W-1:0] < CNT_W'(MAX_PREFIX));
        len       = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + CNT_W'(1);
        short_rec = (i_event_size >= len);
        fdiff     = {1'b0, len} - {1'b0, i_text_offset};
        field     = fdiff[CNT_W] ? '0 : fdiff[CNT_W-1:0];
        field_cap = (field > CNT_W'(MAX_PREFIX)) ? LW'(MAX_PREFIX) : LW'(field);
        verdict.decided      = short_rec;
        verdict.short_record = short_rec;
        verdict.allowed      = 1'b1;
        verdict.matched_rule = MATCH_W'(NUM_RULES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept && is_record) begin
                r_count <= i_req.is_last ? '0 : len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req;
            r_qa      <= AW'(qdiff[CNT_W-1:0]);
            r_qhit    <= qhit;
            r_field   <= field_cap;
            r_verdict <= verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_req     = r_req;
    assign o_qa      = r_qa;
    assign o_qhit    = r_qhit;
    assign o_field   = r_field;
    assign o_verdict = r_verdict;

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_record && i_req.is_last |=> r_count == '0)
        else $error("byte count not cleared after last byte");

endmodule

`default_nettype wire

// ===== src/fmpf_cell.sv =====
// Rule cell: one rule's prefix store, length, allow bit and match progress.
`default_nettype none

module fmpf_cell import fmpf_pkg::*; #(
    parameter int IDX        = 0,
    parameter int MAX_PREFIX = 32,
    parameter int AW         = 5,
    parameter int LW         = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [ACTIVE_W-1:0] i_active_rules,
    input  wire logic                i_valid,
    output      logic                o_ready,
    input  wire t_req                i_req,
    input  wire logic [AW-1:0]       i_qa,
    input  wire logic                i_qhit,
    input  wire logic [LW-1:0]       i_field,
    input  wire t_verdict            i_verdict,
    output      logic                o_valid,
    input  wire logic                i_ready,
    output      t_req                o_req,
    output      logic [AW-1:0]       o_qa,
    output      logic                o_qhit,
    output      logic [LW-1:0]       o_field,
    output      t_verdict            o_verdict
);
    localparam logic [7:0] IDX_W = 8'(IDX);

    logic          r_valid;
    t_req          r_req;
    logic [AW-1:0] r_qa;
    logic          r_qhit;
    logic [LW-1:0] r_field;
    t_verdict      r_verdict;
    logic [LW-1:0] r_len;
    logic          r_allow;
    logic          r_match;
    logic          r_term;

    logic              take;
    logic              leave;
    logic              we;
    logic [BYTE_W-1:0] rdata;
    logic              is_record;
    logic              cmp_en;
    logic              n_match;
    logic              n_term;
    logic              hit;
    logic              in_use;
    logic [8:0]        len_in;

    assign o_ready   = !r_valid || i_ready;
    assign take      = i_valid && o_ready;
    assign leave     = r_valid && i_ready;
    assign we        = take && (i_req.req_type == REQ_LOAD_CHAR)
                       && ({5'd0, i_req.rule_index} == IDX_W)
                       && ({4'd0, i_req.char_pos} < 9'(MAX_PREFIX));

    fmpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PREFIX)
    ) u_prefix (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_req.char_pos)),
        .i_wdata (i_req.rule_char),
        .i_re    (take),
        .i_raddr (i_qa),
        .o_rdata (rdata)
    );

    assign is_record = (r_req.req_type == REQ_RECORD);
    assign cmp_en    = is_record && r_qhit && (LW'(r_qa) < r_len) && !r_term;
    assign in_use    = IDX_W < {4'd0, i_active_rules};
    assign len_in    = ({3'd0, i_req.rule_length} > 9'(MAX_PREFIX))
                       ? 9'(MAX_PREFIX) : {3'd0, i_req.rule_length};

    always_comb begin
        n_match = r_match;
        n_term  = r_term;
        if (cmp_en) begin
            if (rdata != r_req.data_byte) begin
                n_match = 1'b0;
            end else if (rdata == '0) begin
                n_term = 1'b1;
            end
        end
        hit       = (r_len == '0) || ((r_field >= r_len) && n_match);
        o_verdict = r_verdict;
        if (is_record && r_req.is_last && !r_verdict.decided && in_use && hit) begin
            o_verdict.decided      = 1'b1;
            o_verdict.allowed      = r_allow;
            o_verdict.matched_rule = MATCH_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_len   <= '0;
            r_allow <= 1'b1;
            r_match <= 1'b1;
            r_term  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (leave && is_record) begin
                r_match <= r_req.is_last ? 1'b1 : n_match;
                r_term  <= r_req.is_last ? 1'b0 : n_term;
            end
            if (take && (i_req.req_type == REQ_LOAD_LEN)
                    && ({5'd0, i_req.rule_index} == IDX_W)) begin
                r_len   <= LW'(len_in);
                r_allow <= i_req.rule_allow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req     <= i_req;
            r_qa      <= i_qa;
            r_qhit    <= i_qhit;
            r_field   <= i_field;
            r_verdict <= i_verdict;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_qa    = r_qa;
    assign o_qhit  = r_qhit;
    assign o_field = r_field;

endmodule

`default_nettype wire

// ===== src/first_match_prefix_filter_core.sv =====
// Top level: first-match prefix rule filter, head stage, rule cell chain, result register.
//
//  channel  | dir | word                                              | accepted when
//  i_in     | in  | req_type, rule_index, char_pos, rule_char,        | valid & ready
//           |     | rule_length, rule_allow, data_byte, is_last       |
//  o_out    | out | allowed, short_record, matched_rule               | valid & ready
//  i_cfg    | in  | index, data (0 active_rules, 1 event_size,        | valid & ready
//           |     | 2 text_offset)                                    |
//
//  One word per cycle unless a stalled result backs up the chain. A word passes the
//  head stage and then each rule cell in turn; the last cell feeds the result register.
//  Rule loads take effect as the word reaches each cell, so later words see them.
//  Synchronous active-low reset clears control, rule lengths, allow bits and
//  match progress; prefix bytes hold no reset value.
//  A stalled result holds in the output register and the chain fills behind it.
`default_nettype none

module first_match_prefix_filter_core import fmpf_pkg::*; #(
    parameter int NUM_RULES  = 8,
    parameter int MAX_PREFIX = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fmpf_in_if.sink     i_in,
    fmpf_out_if.source  o_out,
    fmpf_cfg_if.sink    i_cfg
);
    localparam int AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
    localparam int LW = $clog2(MAX_PREFIX + 1);

    logic [ACTIVE_W-1:0] r_active_rules;
    logic [CNT_W-1:0]    r_event_size;
    logic [CNT_W-1:0]    r_text_offset;
    logic                r_out_valid;
    t_verdict            r_out;

    t_req     in_req;
    logic     l_valid   [NUM_RULES+1];
    logic     l_ready   [NUM_RULES+1];
    t_req     l_req     [NUM_RULES+1];
    logic [AW-1:0] l_qa [NUM_RULES+1];
    logic     l_qhit    [NUM_RULES+1];
    logic [LW-1:0] l_field [NUM_RULES+1];
    t_verdict l_verdict [NUM_RULES+1];

    logic out_free;
    logic is_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_rules <= '0;
            r_event_size   <= '0;
            r_text_offset  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ACTIVE_RULES: r_active_rules <= i_cfg.data[ACTIVE_W-1:0];
                CFG_EVENT_SIZE:   r_event_size   <= i_cfg.data;
                CFG_TEXT_OFFSET:  r_text_offset  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign in_req = '{
        req_type:    i_in.req_type,
        rule_index:  i_in.rule_index,
        char_pos:    i_in.char_pos,
        rule_char:   i_in.rule_char,
        rule_length: i_in.rule_length,
        rule_allow:  i_in.rule_allow,
        data_byte:   i_in.data_byte,
        is_last:     i_in.is_last
    };

    fmpf_head #(
        .NUM_RULES  (NUM_RULES),
        .MAX_PREFIX (MAX_PREFIX),
        .AW         (AW),
        .LW         (LW)
    ) u_head (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_event_size  (r_event_size),
        .i_text_offset (r_text_offset),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_req         (in_req),
        .o_valid       (l_valid[0]),
        .i_ready       (l_ready[0]),
        .o_req         (l_req[0]),
        .o_qa          (l_qa[0]),
        .o_qhit        (l_qhit[0]),
        .o_field       (l_field[0]),
        .o_verdict     (l_verdict[0])
    );

    for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
        fmpf_cell #(
            .IDX        (g),
            .MAX_PREFIX (MAX_PREFIX),
            .AW         (AW),
            .LW         (LW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_active_rules (r_active_rules),
            .i_valid        (l_valid[g]),
            .o_ready        (l_ready[g]),
            .i_req          (l_req[g]),
            .i_qa           (l_qa[g]),
            .i_qhit         (l_qhit[g]),
            .i_field        (l_field[g]),
            .i_verdict      (l_verdict[g]),
            .o_valid        (l_valid[g+1]),
            .i_ready        (l_ready[g+1]),
            .o_req          (l_req[g+1]),
            .o_qa           (l_qa[g+1]),
            .o_qhit         (l_qhit[g+1]),
            .o_field        (l_field[g+1]),
            .o_verdict      (l_verdict[g+1])
        );
    end

    // only a last record byte leaves a result; other words drop off the chain end
    assign out_free           = !r_out_valid || o_out.ready;
    assign is_result          = (l_req[NUM_RULES].req_type == REQ_RECORD)
                                && l_req[NUM_RULES].is_last;
    assign l_ready[NUM_RULES] = out_free || !is_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= l_valid[NUM_RULES] && is_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && l_valid[NUM_RULES] && is_result) begin
            r_out <= l_verdict[NUM_RULES];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.allowed      = r_out.allowed;
    assign o_out.short_record = r_out.short_record;
    assign o_out.matched_rule = r_out.matched_rule;

    a_short_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.short_record
        |-> r_out.allowed && (r_out.matched_rule == MATCH_W'(NUM_RULES)))
        else $error("short record not allowed or carries a rule");

    a_nomatch_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.matched_rule == MATCH_W'(NUM_RULES)) |-> r_out.allowed)
        else $error("record dropped with no deciding rule");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result lost");

endmodule

`default_nettype wire

// ===== tb/fmpf_verdict_checker.sv =====
// Checker: watches the filter channels, predicts each record verdict and compares.
`default_nettype none

module fmpf_verdict_checker import fmpf_pkg::*; #(
    parameter int NUM_RULES  = 8,
    parameter int MAX_PREFIX = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fmpf_in_if        i_in,
    fmpf_out_if       o_out,
    fmpf_cfg_if       i_cfg,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic               allowed;
        logic               short_record;
        logic [MATCH_W-1:0] matched_rule;
    } t_rec_verdict;

    logic [BYTE_W-1:0]   rule_bytes [NUM_RULES][MAX_PREFIX];
    int                  rule_len [NUM_RULES];
    logic                rule_allow_bit [NUM_RULES];
    logic                rule_live [NUM_RULES];
    logic                rule_stopped [NUM_RULES];
    logic [CNT_W-1:0]    record_len;
    logic [ACTIVE_W-1:0] active_rules_reg;
    logic [CNT_W-1:0]    event_size_reg;
    logic [CNT_W-1:0]    text_offset_reg;
    t_rec_verdict        pending_verdicts [$];
    int                  mismatches;

    function automatic void clear_record();
        record_len = '0;
        for (int r = 0; r < NUM_RULES; r++) begin
            rule_live[r]    = 1'b1;
            rule_stopped[r] = 1'b0;
        end
    endfunction

    function automatic void reset_filter();
        for (int r = 0; r < NUM_RULES; r++) begin
            rule_len[r]       = 0;
            rule_allow_bit[r] = 1'b1;
        end
        clear_record();
        active_rules_reg = '0;
        event_size_reg   = '0;
        text_offset_reg  = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ACTIVE_RULES: active_rules_reg = data[ACTIVE_W-1:0];
            CFG_EVENT_SIZE:   event_size_reg   = data;
            CFG_TEXT_OFFSET:  text_offset_reg  = data;
            default: ;
        endcase
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // one accepted input word; queues a verdict at the last byte of a record
    function automatic void filter_word(t_req w);
        int           len;
        int           pos;
        int           q;
        int           field_len;
        int           rules_used;
        int           r;
        logic         found;
        t_rec_verdict v;
        case (w.req_type)
            REQ_LOAD_CHAR: begin
                if (w.rule_index < NUM_RULES && w.char_pos < MAX_PREFIX)
                    rule_bytes[w.rule_index][w.char_pos] = w.rule_char;
            end
            REQ_LOAD_LEN: begin
                len = w.rule_length;
                if (len > MAX_PREFIX)
                    len = MAX_PREFIX;
                if (w.rule_index < NUM_RULES) begin
                    rule_len[w.rule_index]       = len;
                    rule_allow_bit[w.rule_index] = w.rule_allow;
                end
            end
            REQ_RECORD: begin
                pos = record_len;
                if (pos >= int'(text_offset_reg)) begin
                    q = pos - int'(text_offset_reg);
                    for (r = 0; r < NUM_RULES; r++) begin
                        if (q < rule_len[r] && q < MAX_PREFIX && !rule_stopped[r]) begin
                            if (rule_bytes[r][q] != w.data_byte)
                                rule_live[r] = 1'b0;
                            else if (rule_bytes[r][q] == '0)
                                rule_stopped[r] = 1'b1;
                        end
                    end
                end
                if (record_len != '1)
                    record_len = record_len + 1'b1;
                if (w.is_last) begin
                    v.allowed      = 1'b1;
                    v.short_record = 1'b0;
                    v.matched_rule = MATCH_W'(NUM_RULES);
                    pos = record_len;
                    if (int'(event_size_reg) >= pos) begin
                        v.short_record = 1'b1;
                    end else begin
                        field_len  = (pos > int'(text_offset_reg)) ?
                                     pos - int'(text_offset_reg) : 0;
                        rules_used = (active_rules_reg > NUM_RULES) ?
                                     NUM_RULES : int'(active_rules_reg);
                        found = 1'b0;
                        for (r = 0; r < rules_used; r++) begin
                            if (!found && (rule_len[r] == 0 ||
                                (field_len >= rule_len[r] && rule_live[r]))) begin
                                found          = 1'b1;
                                v.allowed      = rule_allow_bit[r];
                                v.matched_rule = MATCH_W'(r);
                            end
                        end
                    end
                    clear_record();
                    pending_verdicts = {pending_verdicts, v};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_verdict();
        t_rec_verdict got;
        t_rec_verdict want;
        got = '{o_out.allowed, o_out.short_record, o_out.matched_rule};
        if (pending_verdicts.size() == 0) begin
            note_failure($sformatf("verdict with none expected: allowed %b short %b rule %0d",
                                   got.allowed, got.short_record, got.matched_rule));
        end else begin
            want = pending_verdicts.pop_front();
            if (got.allowed !== want.allowed || got.short_record !== want.short_record ||
                got.matched_rule !== want.matched_rule)
                note_failure($sformatf(
                    "expected allowed %b short %b rule %0d, got allowed %b short %b rule %0d",
                    want.allowed, want.short_record, want.matched_rule,
                    got.allowed, got.short_record, got.matched_rule));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_filter();
            pending_verdicts.delete();
            mismatches = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                apply_reg(i_cfg.index, i_cfg.data);
            if (o_out.valid && o_out.ready)
                check_verdict();
            if (i_in.valid && i_in.ready)
                filter_word('{i_in.req_type, i_in.rule_index, i_in.char_pos, i_in.rule_char,
                              i_in.rule_length, i_in.rule_allow, i_in.data_byte,
                              i_in.is_last});
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_verdicts.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_first_match_prefix_filter_core.sv =====
// Testbench top: drives rule loads, records and register writes into the filter.
`default_nettype none

module tb_first_match_prefix_filter_core import fmpf_pkg::*;;

    localparam int NUM_RULES    = 8;
    localparam int MAX_PREFIX   = 32;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = NUM_RULES + 10;
    localparam int PHASE_WORDS  = 130;
    localparam int NUM_PHASES   = 7;
    localparam int CNT_MAX      = 65535;

    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    fmpf_in_if  in_ch();
    fmpf_out_if out_ch();
    fmpf_cfg_if cfg_ch();

    first_match_prefix_filter_core #(
        .NUM_RULES  (NUM_RULES),
        .MAX_PREFIX (MAX_PREFIX)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    fmpf_verdict_checker #(
        .NUM_RULES  (NUM_RULES),
        .MAX_PREFIX (MAX_PREFIX)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus-side copy of the rule table, used to build matching records
    logic [BYTE_W-1:0] shadow_bytes [NUM_RULES][MAX_PREFIX];
    bit                byte_written [NUM_RULES][MAX_PREFIX];
    int                shadow_len [NUM_RULES];
    int                cur_offset;
    int                burst_left;
    int                words_sent;
    int                idle_cycles;

    // receiver stall pattern
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       tick;
        out_ch.ready <= 1'b0;
        mode_left = 0;
        tick      = 0;
        rx_mode   = RX_OPEN;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 128);
            end
            mode_left--;
            tick++;
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   out_ch.ready <= tick[2];
            endcase
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_req noise_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_req)-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char();
        if ($urandom_range(0, 7) == 0)
            return '0;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_len();
        int s;
        s = $urandom_range(0, 15);
        if (s < 10)
            return $urandom_range(0, 6);
        if (s < 14)
            return $urandom_range(7, MAX_PREFIX);
        return $urandom_range(MAX_PREFIX + 1, 63);
    endfunction

    task automatic push_word(t_req w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= w.req_type;
        in_ch.rule_index  <= w.rule_index;
        in_ch.char_pos    <= w.char_pos;
        in_ch.rule_char   <= w.rule_char;
        in_ch.rule_length <= w.rule_length;
        in_ch.rule_allow  <= w.rule_allow;
        in_ch.data_byte   <= w.data_byte;
        in_ch.is_last     <= w.is_last;
        do @(posedge clk); while (!in_ch.ready);
        if (w.req_type != REQ_UNUSED)
            words_sent++;
    endtask

    task automatic load_char(int r, int p, logic [BYTE_W-1:0] c);
        t_req w;
        w = noise_word();
        w.req_type   = REQ_LOAD_CHAR;
        w.rule_index = RIDX_W'(r);
        w.char_pos   = CPOS_W'(p);
        w.rule_char  = c;
        push_word(w);
        shadow_bytes[r][p] = c;
        byte_written[r][p] = 1'b1;
    endtask

    // prefix bytes under the new length are written first, so none is read unwritten
    task automatic set_rule(int r, int len, logic allow);
        t_req w;
        int   stored;
        stored = (len > MAX_PREFIX) ? MAX_PREFIX : len;
        for (int p = 0; p < stored; p++)
            if (!byte_written[r][p])
                load_char(r, p, pick_char());
        w = noise_word();
        w.req_type    = REQ_LOAD_LEN;
        w.rule_index  = RIDX_W'(r);
        w.rule_length = RLEN_W'(len);
        w.rule_allow  = allow;
        push_word(w);
        shadow_len[r] = stored;
    endtask

    task automatic rec_byte(logic [BYTE_W-1:0] b, logic last);
        t_req w;
        w = noise_word();
        w.req_type  = REQ_RECORD;
        w.data_byte = b;
        w.is_last   = last;
        push_word(w);
    endtask

    task automatic push_noise();
        t_req w;
        w = noise_word();
        w.req_type = REQ_UNUSED;
        push_word(w);
    endtask

    // record whose text field follows the prefix of one rule, with some damage
    task automatic send_record(int target, int rec_len, int corrupt_pct, bit mid_loads);
        int                pos;
        int                q;
        logic [BYTE_W-1:0] b;
        for (int p = 0; p < rec_len; p++) begin
            pos = (p > CNT_MAX) ? CNT_MAX : p;
            b   = BYTE_W'($urandom_range(0, 255));
            if (pos >= cur_offset) begin
                q = pos - cur_offset;
                if (q < shadow_len[target]) begin
                    b = shadow_bytes[target][q];
                    if ($urandom_range(0, 99) < corrupt_pct)
                        b = b ^ BYTE_W'($urandom_range(1, 255));
                end
            end
            if (mid_loads && $urandom_range(0, 99) < 3)
                load_char($urandom_range(0, NUM_RULES - 1), $urandom_range(0, MAX_PREFIX - 1),
                          pick_char());
            rec_byte(b, p == rec_len - 1);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_regs(int rules, int ev_size, int offset);
        settle();
        write_reg(CFG_ACTIVE_RULES, rules);
        write_reg(CFG_EVENT_SIZE, ev_size);
        write_reg(CFG_TEXT_OFFSET, offset);
        cfg_ch.valid <= 1'b0;
        cur_offset = offset & CNT_MAX;
    endtask

    task automatic run_phase(int count);
        int goal;
        int sel;
        int target;
        int rec_len;
        goal = words_sent + count;
        while (words_sent < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                set_rule($urandom_range(0, NUM_RULES - 1), pick_len(), 1'($urandom_range(0, 1)));
            end else if (sel < 14) begin
                load_char($urandom_range(0, NUM_RULES - 1), $urandom_range(0, MAX_PREFIX - 1),
                          pick_char());
            end else if (sel < 18) begin
                push_noise();
            end else begin
                target = $urandom_range(0, NUM_RULES - 1);
                if (cur_offset <= 8) begin
                    rec_len = cur_offset + shadow_len[target] + $urandom_range(0, 3);
                    if ($urandom_range(0, 7) == 0)
                        rec_len = $urandom_range(1, cur_offset + shadow_len[target] + 1);
                    if (rec_len < 1)
                        rec_len = 1;
                end else begin
                    rec_len = $urandom_range(1, 12);
                end
                send_record(target, rec_len, 8, 1'b1);
            end
        end
    endtask

    initial begin
        int phase_rules  [NUM_PHASES];
        int phase_event  [NUM_PHASES];
        int phase_offset [NUM_PHASES];
        phase_rules  = '{8, 3, 16'hA50F, 0, 8, 5, 8};
        phase_event  = '{0, 4, 1, CNT_MAX, 0, 3, 0};
        phase_offset = '{0, 2, 1, CNT_MAX, CNT_MAX, 5, 0};

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.req_type    <= REQ_RECORD;
        in_ch.rule_index  <= '0;
        in_ch.char_pos    <= '0;
        in_ch.rule_char   <= '0;
        in_ch.rule_length <= '0;
        in_ch.rule_allow  <= 1'b0;
        in_ch.data_byte   <= '0;
        in_ch.is_last     <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_ACTIVE_RULES;
        cfg_ch.data       <= '0;
        idle_cycles = 0;
        burst_left  = 0;
        words_sent  = 0;
        cur_offset  = 0;
        for (int r = 0; r < NUM_RULES; r++) begin
            shadow_len[r] = 0;
            for (int p = 0; p < MAX_PREFIX; p++)
                byte_written[r][p] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // no active rules: everything allowed, no rule decides
        rec_byte(8'h12, 1'b0);
        rec_byte(8'h34, 1'b0);
        rec_byte(8'h56, 1'b1);
        push_noise();

        settle();
        write_reg(CFG_ACTIVE_RULES, 8);
        write_reg(CFG_EVENT_SIZE, 0);
        write_reg(CFG_TEXT_OFFSET, 0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_ch.valid <= 1'b0;
        cur_offset = 0;

        load_char(0, 0, 8'h55);
        load_char(0, 1, 8'hAA);
        set_rule(0, 2, 1'b0);
        load_char(1, 0, 8'hFF);
        load_char(1, 1, 8'h00);
        load_char(1, 2, 8'h41);
        set_rule(1, 3, 1'b0);
        rec_byte(8'h55, 1'b0);
        rec_byte(8'hAA, 1'b1);
        // zero byte ends the compare early
        rec_byte(8'hFF, 1'b0);
        rec_byte(8'h00, 1'b0);
        rec_byte(8'h7E, 1'b1);
        // text too short for rule 1, empty rule 2 decides
        rec_byte(8'hFF, 1'b0);
        rec_byte(8'h00, 1'b1);

        set_regs(8, 2, 0);
        rec_byte(8'h55, 1'b0);
        rec_byte(8'hAA, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_regs(phase_rules[ph], phase_event[ph], phase_offset[ph]);
            run_phase(PHASE_WORDS);
        end

        set_regs(8, 0, 0);
        run_phase(PHASE_WORDS);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/fmpf_pkg.sv
src/fmpf_if.sv
src/fmpf_ram.sv
src/fmpf_head.sv
src/fmpf_cell.sv
src/first_match_prefix_filter_core.sv
tb/fmpf_verdict_checker.sv
tb/tb_first_match_prefix_filter_core.sv
